### rtl/hlpd_pkg.sv
`timescale 1ns / 1ps
// Package for the hover-lock proximity dimmer: operation codes, level widths,
// register reset values and the stage payload types. No dependencies.
package hlpd_pkg;

    localparam int FULL_SCALE  = 1000;
    localparam int LEVEL_W     = 10;
    localparam int TARGET_W    = 12;
    localparam int PROD_W      = 2 * LEVEL_W;
    localparam int RECIP_SHIFT = PROD_W + LEVEL_W;
    localparam int RECIP_W     = RECIP_SHIFT - LEVEL_W + 1;
    localparam int RECIP_PROD_W = PROD_W + RECIP_W;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(FULL_SCALE);
    localparam logic [RECIP_W-1:0] RECIP_MULT =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE));

    localparam logic [7:0]  THRESH_RESET   = 8'd5;
    localparam logic [15:0] LOCK_RESET     = 16'd850;
    localparam logic [15:0] INTERVAL_RESET = 16'd50;
    localparam logic [7:0]  OFFSET_RESET   = 8'd20;
    localparam logic [3:0]  GAIN_RESET     = 4'd5;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_REARM  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        REG_THRESH   = 3'd0,
        REG_LOCK     = 3'd1,
        REG_INTERVAL = 3'd2,
        REG_OFFSET   = 3'd3,
        REG_GAIN     = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [7:0]         sample;
        logic               local_mode;
        logic               focus_color;
        logic [LEVEL_W-1:0] bri;
        logic [LEVEL_W-1:0] cct;
    } in_item_t;

    typedef struct packed {
        logic               update;
        logic               locked;
        logic [LEVEL_W-1:0] bri;
        logic [LEVEL_W-1:0] cct;
        logic [PROD_W-1:0]  prod;
        logic [LEVEL_W-1:0] quot;
    } lvl_item_t;

endpackage

### rtl/hover_lock_proximity_dimmer.sv
`timescale 1ns / 1ps
// Hover-lock proximity dimmer top level: decision stage, duty product,
// constant divide and result register. Depends on hlpd_pkg.
//
// One transfer is accepted every cycle while the result side keeps up; each
// result passes in order through the input register, lock/level decision,
// cct*bri product, reciprocal divide by full scale and result register.
// The time counter, lock flag and timestamps update as an item leaves the
// input register, so back-to-back items always see the state left by the
// one before. Configuration writes are taken every cycle (cfg_ready is
// always high).
module hover_lock_proximity_dimmer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic [7:0]                    s_sample,
    input  logic                          s_local_mode,
    input  logic                          s_focus_color,
    input  logic [hlpd_pkg::LEVEL_W-1:0]  s_held_brightness,
    input  logic [hlpd_pkg::LEVEL_W-1:0]  s_held_color_temp,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_update_valid,
    output logic [hlpd_pkg::LEVEL_W-1:0]  m_new_brightness,
    output logic [hlpd_pkg::LEVEL_W-1:0]  m_new_color_temp,
    output logic [hlpd_pkg::LEVEL_W-1:0]  m_warm_duty,
    output logic [hlpd_pkg::LEVEL_W-1:0]  m_cold_duty,
    output logic                          m_is_locked
);
    import hlpd_pkg::*;

    logic [7:0]  thresh_reg;
    logic [15:0] lock_time_reg;
    logic [15:0] interval_reg;
    logic [7:0]  offset_reg;
    logic [3:0]  gain_reg;

    logic [31:0] now_reg, now_next;
    logic        locked_reg, locked_next;
    logic [7:0]  last_sample_reg, last_sample_next;
    logic [31:0] stable_since_reg, stable_since_next;
    logic [31:0] last_update_reg, last_update_next;

    logic      s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, m_valid_reg;
    in_item_t  s1_reg;
    lvl_item_t s2_reg, s2_next;
    lvl_item_t s3_reg, s3_next;
    lvl_item_t s4_reg, s4_next;

    logic free_out, free4, free3, free2, free1, s1_fire;

    logic [LEVEL_W-1:0]      out_bri_reg, out_cct_reg, out_warm_reg, out_cold_reg;
    logic                    out_update_reg, out_locked_reg;
    logic [LEVEL_W-1:0]      warm_next;
    logic                    inexact;
    logic [RECIP_PROD_W-1:0] recip_prod;

    logic [7:0]          diff;
    logic [31:0]         stable_age, update_age;
    logic [7:0]          above_offset;
    logic [TARGET_W-1:0] raw_target;
    logic [LEVEL_W-1:0]  target;
    logic                lock_now;

    assign cfg_ready = 1'b1;

    assign free_out = !m_valid_reg || m_ready;
    assign free4    = !s4_valid_reg || free_out;
    assign free3    = !s3_valid_reg || free4;
    assign free2    = !s2_valid_reg || free3;
    assign free1    = !s1_valid_reg || free2;
    assign s_ready  = free1;
    assign s1_fire  = s1_valid_reg && free2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg    <= THRESH_RESET;
            lock_time_reg <= LOCK_RESET;
            interval_reg  <= INTERVAL_RESET;
            offset_reg    <= OFFSET_RESET;
            gain_reg      <= GAIN_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_THRESH:   thresh_reg    <= cfg_data[7:0];
                REG_LOCK:     lock_time_reg <= cfg_data;
                REG_INTERVAL: interval_reg  <= cfg_data;
                REG_OFFSET:   offset_reg    <= cfg_data[7:0];
                REG_GAIN:     gain_reg      <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // decision stage
    always_comb begin
        diff = (s1_reg.sample >= last_sample_reg) ? s1_reg.sample - last_sample_reg
                                                  : last_sample_reg - s1_reg.sample;
        stable_age   = now_reg - stable_since_reg;
        update_age   = now_reg - last_update_reg;
        above_offset = (s1_reg.sample > offset_reg) ? s1_reg.sample - offset_reg : 8'd0;
        raw_target   = TARGET_W'(above_offset) * TARGET_W'(gain_reg);
        target       = (raw_target > TARGET_W'(FULL_SCALE)) ? FULL_LEVEL
                                                            : raw_target[LEVEL_W-1:0];

        now_next          = now_reg;
        locked_next       = locked_reg;
        last_sample_next  = last_sample_reg;
        stable_since_next = stable_since_reg;
        last_update_next  = last_update_reg;
        lock_now          = 1'b0;

        s2_next        = '0;
        s2_next.bri    = s1_reg.bri;
        s2_next.cct    = s1_reg.cct;

        case (s1_reg.op)
            OP_TICK: begin
                now_next = now_reg + 32'd1;
            end
            OP_REARM: begin
                if (s1_reg.local_mode) begin
                    locked_next       = 1'b0;
                    last_sample_next  = 8'd0;
                    stable_since_next = now_reg;
                end
            end
            OP_SAMPLE: begin
                if (s1_reg.local_mode && !locked_reg) begin
                    if (diff > thresh_reg) begin
                        last_sample_next  = s1_reg.sample;
                        stable_since_next = now_reg;
                    end else if (stable_age > 32'(lock_time_reg)) begin
                        locked_next = 1'b1;
                        lock_now    = 1'b1;
                    end
                    if (!lock_now && update_age > 32'(interval_reg)) begin
                        last_update_next = now_reg;
                        s2_next.update   = 1'b1;
                        if (s1_reg.focus_color) begin
                            s2_next.cct = target;
                        end else begin
                            s2_next.bri = target;
                        end
                    end
                end
            end
            default: ;
        endcase
        s2_next.locked = locked_next;
    end

    always_comb begin
        s3_next      = s2_reg;
        s3_next.prod = PROD_W'(s2_reg.cct) * PROD_W'(s2_reg.bri);
    end

    always_comb begin
        recip_prod   = RECIP_PROD_W'(s3_reg.prod) * RECIP_PROD_W'(RECIP_MULT);
        s4_next      = s3_reg;
        s4_next.quot = recip_prod[RECIP_SHIFT +: LEVEL_W];
    end

    // warm = bri - ceil(cct*bri / full scale)
    always_comb begin
        inexact   = s4_reg.prod != (PROD_W'(s4_reg.quot) * PROD_W'(FULL_SCALE));
        warm_next = s4_reg.bri - s4_reg.quot - LEVEL_W'(inexact);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg          <= '0;
            locked_reg       <= 1'b0;
            last_sample_reg  <= '0;
            stable_since_reg <= '0;
            last_update_reg  <= '0;
        end else if (s1_fire) begin
            now_reg          <= now_next;
            locked_reg       <= locked_next;
            last_sample_reg  <= last_sample_next;
            stable_since_reg <= stable_since_next;
            last_update_reg  <= last_update_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (free1) begin
                s1_valid_reg <= s_valid;
            end
            if (free2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (free3) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (free4) begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (free_out) begin
                m_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (free1) begin
            s1_reg.op          <= s_operation;
            s1_reg.sample      <= s_sample;
            s1_reg.local_mode  <= s_local_mode;
            s1_reg.focus_color <= s_focus_color;
            s1_reg.bri <= (s_held_brightness > FULL_LEVEL) ? FULL_LEVEL : s_held_brightness;
            s1_reg.cct <= (s_held_color_temp > FULL_LEVEL) ? FULL_LEVEL : s_held_color_temp;
        end
        if (free2) begin
            s2_reg <= s2_next;
        end
        if (free3) begin
            s3_reg <= s3_next;
        end
        if (free4) begin
            s4_reg <= s4_next;
        end
        if (free_out) begin
            out_update_reg <= s4_reg.update;
            out_locked_reg <= s4_reg.locked;
            out_bri_reg    <= s4_reg.update ? s4_reg.bri  : '0;
            out_cct_reg    <= s4_reg.update ? s4_reg.cct  : '0;
            out_warm_reg   <= s4_reg.update ? warm_next   : '0;
            out_cold_reg   <= s4_reg.update ? s4_reg.quot : '0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_update_valid   = out_update_reg;
    assign m_new_brightness = out_bri_reg;
    assign m_new_color_temp = out_cct_reg;
    assign m_warm_duty      = out_warm_reg;
    assign m_cold_duty      = out_cold_reg;
    assign m_is_locked      = out_locked_reg;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for hover_lock_proximity_dimmer: directed and random
// tick/sample/rearm traffic, predicted levels checked in order. Needs hlpd_pkg.
module testbench;
    import hlpd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic               update;
        logic [LEVEL_W-1:0] bri;
        logic [LEVEL_W-1:0] cct;
        logic [LEVEL_W-1:0] warm;
        logic [LEVEL_W-1:0] cold;
        logic               locked;
    } levels_t;

    class dimmer_board;
        logic [7:0]  thresh_r;
        logic [15:0] lock_r;
        logic [15:0] interval_r;
        logic [7:0]  offset_r;
        logic [3:0]  gain_r;
        logic [31:0] clock_ms;
        logic [31:0] stable_since;
        logic [31:0] last_update;
        logic [7:0]  stable_sample;
        bit          lock_flag;
        levels_t     levels_due[$];
        int          errors;
        int          results_seen;
        int          updates_seen;
        int          locks_predicted;

        function new();
            thresh_r = THRESH_RESET;
            lock_r = LOCK_RESET;
            interval_r = INTERVAL_RESET;
            offset_r = OFFSET_RESET;
            gain_r = GAIN_RESET;
            clock_ms = '0;
            stable_since = '0;
            last_update = '0;
            stable_sample = '0;
            lock_flag = 1'b0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                REG_THRESH:   thresh_r = data[7:0];
                REG_LOCK:     lock_r = data;
                REG_INTERVAL: interval_r = data;
                REG_OFFSET:   offset_r = data[7:0];
                REG_GAIN:     gain_r = data[3:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return levels_due.size();
        endfunction

        function void take_input(in_item_t it);
            int unsigned bri, cct, target, diff, warm, cold;
            logic [31:0] held_for, since_update;
            bit          upd, lock_now;
            levels_t     want;
            bri = (it.bri > FULL_SCALE) ? FULL_SCALE : it.bri;
            cct = (it.cct > FULL_SCALE) ? FULL_SCALE : it.cct;
            upd = 1'b0;
            lock_now = 1'b0;
            warm = 0;
            cold = 0;
            case (it.op)
                OP_TICK: clock_ms = clock_ms + 32'd1;
                OP_REARM: begin
                    if (it.local_mode) begin
                        lock_flag = 1'b0;
                        stable_sample = '0;
                        stable_since = clock_ms;
                    end
                end
                OP_SAMPLE: begin
                    if (it.local_mode && !lock_flag) begin
                        diff = (it.sample > stable_sample) ? it.sample - stable_sample
                                                           : stable_sample - it.sample;
                        held_for = clock_ms - stable_since;
                        if (diff > thresh_r) begin
                            stable_sample = it.sample;
                            stable_since = clock_ms;
                        end else if (held_for > {16'd0, lock_r}) begin
                            lock_flag = 1'b1;
                            lock_now = 1'b1;
                            locks_predicted++;
                        end
                        if (!lock_now) begin
                            target = 0;
                            if (it.sample > offset_r)
                                target = (it.sample - offset_r) * gain_r;
                            if (target > FULL_SCALE)
                                target = FULL_SCALE;
                            since_update = clock_ms - last_update;
                            if (since_update > {16'd0, interval_r}) begin
                                last_update = clock_ms;
                                if (it.focus_color)
                                    cct = target;
                                else
                                    bri = target;
                                warm = ((FULL_SCALE - cct) * bri) / FULL_SCALE;
                                cold = (cct * bri) / FULL_SCALE;
                                upd = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            want.update = upd;
            want.bri = upd ? LEVEL_W'(bri) : '0;
            want.cct = upd ? LEVEL_W'(cct) : '0;
            want.warm = LEVEL_W'(warm);
            want.cold = LEVEL_W'(cold);
            want.locked = lock_flag;
            levels_due.push_back(want);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 30)
                $display("ERROR @%0t: %s", $realtime, msg);
        endtask

        task cmp_field(string name, int got, int want);
            if (got !== want)
                report($sformatf("result %0d %s got %0d want %0d", results_seen, name, got, want));
        endtask

        task check_levels(levels_t got);
            levels_t want;
            if (levels_due.size() == 0) begin
                report("result transfer with no expected levels outstanding");
                return;
            end
            want = levels_due.pop_front();
            cmp_field("update_valid", int'(got.update), int'(want.update));
            cmp_field("new_brightness", int'(got.bri), int'(want.bri));
            cmp_field("new_color_temp", int'(got.cct), int'(want.cct));
            cmp_field("warm_duty", int'(got.warm), int'(want.warm));
            cmp_field("cold_duty", int'(got.cold), int'(want.cold));
            cmp_field("is_locked", int'(got.locked), int'(want.locked));
            if (want.update)
                updates_seen++;
            results_seen++;
        endtask
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_operation = '0;
    logic [7:0]         s_sample = '0;
    logic               s_local_mode = 1'b0;
    logic               s_focus_color = 1'b0;
    logic [LEVEL_W-1:0] s_held_brightness = '0;
    logic [LEVEL_W-1:0] s_held_color_temp = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_update_valid;
    logic [LEVEL_W-1:0] m_new_brightness;
    logic [LEVEL_W-1:0] m_new_color_temp;
    logic [LEVEL_W-1:0] m_warm_duty;
    logic [LEVEL_W-1:0] m_cold_duty;
    logic               m_is_locked;

    dimmer_board board = new();
    int unsigned cycle_count = 0;
    int unsigned burst_left = 1;
    int unsigned useful_sent = 0;
    int unsigned inputs_sent = 0;
    int unsigned settings_used = 0;
    bit          holdoff_go = 1'b0;
    int unsigned holdoff_left = 0;
    int unsigned rx_cycles = 0;

    hover_lock_proximity_dimmer dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_operation(s_operation),
        .s_sample(s_sample),
        .s_local_mode(s_local_mode),
        .s_focus_color(s_focus_color),
        .s_held_brightness(s_held_brightness),
        .s_held_color_temp(s_held_color_temp),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_update_valid(m_update_valid),
        .m_new_brightness(m_new_brightness),
        .m_new_color_temp(m_new_color_temp),
        .m_warm_duty(m_warm_duty),
        .m_cold_duty(m_cold_duty),
        .m_is_locked(m_is_locked)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d levels outstanding",
                     cycle_count, board.pending());
            $display("hover_lock_proximity_dimmer: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready)
            board.check_levels('{m_update_valid, m_new_brightness, m_new_color_temp,
                                 m_warm_duty, m_cold_duty, m_is_locked});
    end

    // Result side: rotate through stall patterns; honor a long hold-off on request.
    initial begin
        forever begin
            @(negedge aclk);
            if (holdoff_go) begin
                holdoff_go = 1'b0;
                holdoff_left = 90;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_ready <= 1'b0;
            end else begin
                case ((rx_cycles / 200) % 4)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= ((rx_cycles % 7) < 4);
                    default: m_ready <= 1'($urandom_range(0, 1));
                endcase
            end
            rx_cycles++;
        end
    end

    function automatic in_item_t mk(logic [1:0] op, logic [7:0] smp, logic loc, logic foc,
                                    logic [LEVEL_W-1:0] b, logic [LEVEL_W-1:0] c);
        in_item_t it;
        it.op = op;
        it.sample = smp;
        it.local_mode = loc;
        it.focus_color = foc;
        it.bri = b;
        it.cct = c;
        return it;
    endfunction

    function automatic logic [LEVEL_W-1:0] rand_level();
        if ($urandom_range(0, 7) == 0)
            return LEVEL_W'($urandom_range(FULL_SCALE, (1 << LEVEL_W) - 1));
        return LEVEL_W'($urandom_range(0, (1 << LEVEL_W) - 1));
    endfunction

    // Called at a falling edge; returns at a falling edge with valid still high
    // unless the burst ended and a gap was inserted.
    task automatic send_item(input in_item_t it);
        int unsigned gap;
        s_valid <= 1'b1;
        s_operation <= it.op;
        s_sample <= it.sample;
        s_local_mode <= it.local_mode;
        s_focus_color <= it.focus_color;
        s_held_brightness <= it.bri;
        s_held_color_temp <= it.cct;
        do @(posedge aclk); while (s_ready !== 1'b1);
        board.take_input(it);
        inputs_sent++;
        if (it.op == OP_TICK || (it.local_mode && (it.op == OP_SAMPLE || it.op == OP_REARM)))
            useful_sent++;
        @(negedge aclk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Narrow registers get junk in the unused upper bits of the write data.
    task automatic program_registers(logic [7:0] thr, logic [15:0] lck, logic [15:0] ivl,
                                     logic [7:0] ofs, logic [3:0] gn);
        logic [2:0]  idx;
        logic [15:0] data;
        drain();
        for (int k = 0; k < 6; k++) begin
            data = 16'($urandom);
            case (k)
                0: begin idx = REG_THRESH;   data[7:0] = thr; end
                1: begin idx = REG_LOCK;     data = lck; end
                2: begin idx = REG_INTERVAL; data = ivl; end
                3: begin idx = REG_OFFSET;   data[7:0] = ofs; end
                4: begin idx = REG_GAIN;     data[3:0] = gn; end
                default: idx = 3'($urandom_range(5, 7));
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= data;
            do @(posedge aclk); while (cfg_ready !== 1'b1);
            board.set_reg(idx, data);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_mix(int unsigned goal);
        logic [7:0]  base;
        logic        foc;
        int unsigned steps, jit;
        int          v;
        while (useful_sent < goal) begin
            if ($urandom_range(0, 9) < 7) begin
                base = 8'($urandom);
                foc = 1'($urandom_range(0, 1));
                jit = $urandom_range(0, 6);
                steps = $urandom_range(3, 16);
                if ($urandom_range(0, 3) == 0)
                    send_item(mk(OP_REARM, 8'($urandom), 1'b1, foc, rand_level(),
                                 rand_level()));
                for (int s = 0; s < steps; s++) begin
                    repeat ($urandom_range(0, 4))
                        send_item(mk(OP_TICK, 8'($urandom), 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)), rand_level(), rand_level()));
                    v = int'(base) + int'($urandom_range(0, 2 * jit)) - int'(jit);
                    if ($urandom_range(0, 7) == 0)
                        v = $urandom_range(0, 255);
                    v = (v < 0) ? 0 : (v > 255) ? 255 : v;
                    send_item(mk(OP_SAMPLE, 8'(v), 1'b1, foc, rand_level(), rand_level()));
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(mk(2'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), rand_level(), rand_level()));
            end
        end
    endtask

    initial begin
        in_item_t directed[$];
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Directed: extremes, remote mode, lock event, sample while locked, rearm,
        // unused operation code and held levels above full scale.
        program_registers(8'd5, 16'd2, 16'd0, 8'd20, 4'd5);
        directed = '{
            mk(2'd3, 8'hFF, 1'b1, 1'b1, 10'h3FF, 10'h3FF),
            mk(OP_TICK, 8'h00, 1'b0, 1'b0, 10'd0, 10'd0),
            mk(OP_SAMPLE, 8'd255, 1'b1, 1'b0, 10'h3FF, 10'h3FF),
            mk(OP_TICK, 8'hFF, 1'b1, 1'b1, 10'h3FF, 10'h3FF),
            mk(OP_SAMPLE, 8'd0, 1'b1, 1'b1, 10'd0, 10'd1001),
            mk(OP_TICK, 8'h00, 1'b1, 1'b0, 10'd0, 10'd0),
            mk(OP_SAMPLE, 8'd20, 1'b1, 1'b0, 10'd500, 10'd1000),
            mk(OP_TICK, 8'h00, 1'b1, 1'b0, 10'd0, 10'd0),
            mk(OP_SAMPLE, 8'd22, 1'b1, 1'b1, 10'd1000, 10'd0),
            mk(OP_TICK, 8'h00, 1'b1, 1'b0, 10'd0, 10'd0),
            mk(OP_TICK, 8'h00, 1'b1, 1'b0, 10'd0, 10'd0),
            mk(OP_TICK, 8'h00, 1'b1, 1'b0, 10'd0, 10'd0),
            mk(OP_SAMPLE, 8'd21, 1'b1, 1'b0, 10'd700, 10'd300),
            mk(OP_SAMPLE, 8'd200, 1'b1, 1'b0, 10'd700, 10'd300),
            mk(OP_REARM, 8'd0, 1'b0, 1'b0, 10'd700, 10'd300),
            mk(OP_SAMPLE, 8'd100, 1'b0, 1'b1, 10'd700, 10'd300),
            mk(OP_REARM, 8'd0, 1'b1, 1'b0, 10'd700, 10'd300),
            mk(OP_SAMPLE, 8'd3, 1'b1, 1'b1, 10'd1023, 10'd1001),
            mk(2'd3, 8'd0, 1'b0, 1'b0, 10'd0, 10'd0),
            mk(OP_TICK, 8'h00, 1'b1, 1'b0, 10'd0, 10'd0),
            mk(OP_SAMPLE, 8'd255, 1'b1, 1'b1, 10'd1000, 10'd1023)
        };
        foreach (directed[i])
            send_item(directed[i]);

        for (int p = 0; p < 10; p++) begin
            case (p)
                0: program_registers(8'd0, 16'd0, 16'd0, 8'd0, 4'd15);
                1: program_registers(8'd255, 16'hFFFF, 16'hFFFF, 8'd255, 4'd0);
                2: program_registers(THRESH_RESET, LOCK_RESET, INTERVAL_RESET,
                                     OFFSET_RESET, GAIN_RESET);
                default: program_registers(8'($urandom_range(0, 20)),
                                           16'($urandom_range(0, 30)),
                                           16'($urandom_range(0, 8)),
                                           8'($urandom_range(0, 80)),
                                           4'($urandom));
            endcase
            if (p == 4) begin
                holdoff_go = 1'b1;
                burst_left = 70;
            end
            run_mix(useful_sent + (p == 1 ? 60 : 130));
        end
        drain();

        $display("%0d input transfers (%0d acting), %0d results, %0d level updates",
                 inputs_sent, useful_sent, board.results_seen, board.updates_seen);
        $display("%0d lock events across %0d register settings, %0d errors",
                 board.locks_predicted, settings_used, board.errors);
        if (board.errors == 0)
            $display("hover_lock_proximity_dimmer: match");
        else
            $display("hover_lock_proximity_dimmer: mismatch");
        $finish;
    end
endmodule
